// ----- design/bgauge_pkg.sv -----
package bgauge_pkg;

   localparam int ADC_W      = 12;
   localparam int REF_W      = 13;
   localparam int LOAD_W     = 30;
   localparam int CAP_W      = 40;
   localparam int PCT_W      = 14;
   localparam int IDX_W      = 6;
   localparam int V_W        = 17;
   localparam int NUM_W      = 50;
   localparam int DIV_DW     = 56;
   localparam int DIV_SW     = 40;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 64;

   localparam int TOP_POINT  = 42300;
   localparam int POINT_STEP = 100;
   localparam int SCALE_MUL  = 17050;
   localparam int SCALE_DIV  = 1100;
   localparam int SCALE_SH   = 12;
   localparam int PCT_FULL   = 10000;
   localparam int SEG_GAIN   = 9;

   // divide by 1100 as a shift by two and a reciprocal multiply for 275
   localparam int Y_W        = 26;
   localparam int RECIP_MUL  = 124944504;
   localparam int RECIP_SH   = 35;

   localparam logic [REF_W-1:0]  REF_RESET  = REF_W'(3300);
   localparam logic [LOAD_W-1:0] LOAD_RESET = LOAD_W'(10000);
   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1000000);

   typedef enum logic [1:0] {
      CSR_REF  = 2'd0,
      CSR_LOAD = 2'd1,
      CSR_CAP  = 2'd2,
      CSR_NONE = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCALE,
      OP_VSAVE,
      OP_SEG_SQ,
      OP_SEG_ACC,
      OP_EDIV,
      OP_PMUL,
      OP_PDIV,
      OP_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_VDIV,
      ST_BRANCH,
      ST_SQ,
      ST_ACC,
      ST_EDIV,
      ST_EWAIT,
      ST_PDIV,
      ST_PWAIT,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type          op;
      logic [IDX_W-1:0]   seg_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic above;
      logic hit;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/bgauge_ifs.sv -----
interface bgauge_req_if import bgauge_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bgauge_rsp_if import bgauge_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] percent_centi;
   logic             above_table;
   logic             below_table;
   logic             saturated;
   modport source (output valid, output percent_centi, output above_table,
                   output below_table, output saturated, input ready);
   modport sink   (input valid, input percent_centi, input above_table,
                   input below_table, input saturated, output ready);
endinterface

// ----- design/bgauge_div.sv -----
module bgauge_div import bgauge_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_DW-1:0] dividend,
   input  logic [DIV_SW-1:0] divisor,
   output logic              done,
   output logic [DIV_DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_DW);

   logic [DIV_SW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_SW-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_SW:0]   trial;
   logic              fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[DIV_DW-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_SW'(trial - {1'b0, dsr_ff}) : trial[DIV_SW-1:0];
         quo_in = {quo_ff[DIV_DW-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_DW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/bgauge_ctrl.sv -----
module bgauge_ctrl import bgauge_pkg::*; #(
   parameter int TABLE_POINTS = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int IW = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS) : 1;

   ctrl_state_type state_ff, state_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           last_seg;

   assign last_seg = (idx_ff == IW'(TABLE_POINTS - 2));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_VDIV;
         ST_VDIV:   state_in = ST_BRANCH;
         ST_BRANCH: state_in = status.above ? ST_RESULT : ST_SQ;
         ST_SQ:     state_in = ST_ACC;
         ST_ACC:    state_in = (status.hit || last_seg) ? ST_EDIV : ST_SQ;
         ST_EDIV:   state_in = ST_EWAIT;
         ST_EWAIT:  if (status.div_done) state_in = ST_PDIV;
         ST_PDIV:   state_in = ST_PWAIT;
         ST_PWAIT:  if (status.div_done) state_in = ST_RESULT;
         ST_RESULT: if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op      = OP_NONE;
      cmd.seg_idx = IDX_W'(idx_ff);
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_SCALE:  cmd.op = OP_SCALE;
         ST_VDIV:   cmd.op = OP_VSAVE;
         ST_SQ:     cmd.op = OP_SEG_SQ;
         ST_ACC:    cmd.op = OP_SEG_ACC;
         ST_EDIV:   cmd.op = OP_EDIV;
         ST_EWAIT:  if (status.div_done) cmd.op = OP_PMUL;
         ST_PDIV:   cmd.op = OP_PDIV;
         ST_RESULT: if (status.out_free) cmd.op = OP_OUT;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (state_ff == ST_BRANCH) idx_in = '0;
      else if (state_ff == ST_ACC) idx_in = idx_ff + IW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ----- design/bgauge_dp.sv -----
module bgauge_dp import bgauge_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_status_type     status,
   input  logic [ADC_W-1:0]  adc_sample,
   input  logic [REF_W-1:0]  ref_mv,
   input  logic [LOAD_W-1:0] load_mohm,
   input  logic [CAP_W-1:0]  cap_mj,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PCT_W-1:0]  percent_centi,
   output logic              above_table,
   output logic              below_table,
   output logic              saturated
);

   logic [ADC_W+REF_W-1:0] p1_ff, p1_in;
   logic [Y_W-1:0]         y_ff, y_in;
   logic [LOAD_W+6:0]      r100_ff, r100_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [V_W-1:0]         v_ff, v_in;
   logic                   above_ff, above_in;
   logic [35:0]            sq_ff, sq_in;
   logic [9:0]             d9_ff, d9_in;
   logic                   hit_ff, hit_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic                   below_ff, below_in;
   logic                   sat_ff, sat_in;
   logic [CAP_W+13:0]      prod2_ff, prod2_in;
   logic                   valid_ff, valid_in;
   logic [PCT_W-1:0]       pct_ff, pct_in;
   logic                   oabove_ff, oabove_in, obelow_ff, obelow_in, osat_ff, osat_in;

   logic              div_start, div_done;
   logic [DIV_DW-1:0] div_dividend, div_q;
   logic [DIV_SW-1:0] div_divisor;
   logic [39:0]       scaled;
   logic [Y_W+26:0]   vprod;
   logic [V_W-1:0]    hi, lo;
   logic              in_seg;
   logic [17:0]       s;
   logic [6:0]        d;
   logic              e_gt_cap;
   logic [CAP_W-1:0]  diff;

   bgauge_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign scaled = 40'(p1_ff) * 40'(SCALE_MUL);
   assign vprod  = (Y_W+27)'(y_ff) * (Y_W+27)'(RECIP_MUL);

   // table segment bounds for the current walk position
   assign hi     = V_W'(TOP_POINT) - V_W'(cmd.seg_idx) * V_W'(POINT_STEP);
   assign lo     = hi - V_W'(POINT_STEP);
   assign in_seg = (v_ff <= hi) && (v_ff >= lo);
   assign s      = 18'(hi) + 18'(in_seg ? v_ff : lo);
   assign d      = in_seg ? 7'(hi - v_ff) : 7'(POINT_STEP);

   assign e_gt_cap = div_q > DIV_DW'(cap_ff);
   assign diff     = e_gt_cap ? '0 : cap_ff - div_q[CAP_W-1:0];

   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_DW'(num_ff);
      div_divisor  = DIV_SW'(r100_ff);
      unique case (cmd.op)
         OP_EDIV: begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(num_ff);
            div_divisor  = DIV_SW'(r100_ff);
         end
         OP_PDIV: begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(prod2_ff);
            div_divisor  = cap_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   always_comb begin
      p1_in     = p1_ff;
      y_in      = y_ff;
      r100_in   = r100_ff;
      cap_in    = cap_ff;
      v_in      = v_ff;
      above_in  = above_ff;
      sq_in     = sq_ff;
      d9_in     = d9_ff;
      hit_in    = hit_ff;
      num_in    = num_ff;
      below_in  = below_ff;
      sat_in    = sat_ff;
      prod2_in  = prod2_ff;
      pct_in    = pct_ff;
      oabove_in = oabove_ff;
      obelow_in = obelow_ff;
      osat_in   = osat_ff;
      valid_in  = rsp_ready ? 1'b0 : valid_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            p1_in    = (ADC_W+REF_W)'(adc_sample) * (ADC_W+REF_W)'(ref_mv);
            r100_in  = (LOAD_W+7)'(load_mohm == '0 ? LOAD_W'(1) : load_mohm)
                       * (LOAD_W+7)'(POINT_STEP);
            cap_in   = (cap_mj == '0) ? CAP_W'(1) : cap_mj;
            num_in   = '0;
            below_in = 1'b0;
            sat_in   = 1'b0;
            hit_in   = 1'b0;
         end
         OP_SCALE: begin
            // drop the 4096 and the factor 4 of 1100 in one shift
            y_in = scaled[39:SCALE_SH+2];
         end
         OP_VSAVE: begin
            v_in     = vprod[RECIP_SH+V_W-1:RECIP_SH];
            above_in = vprod[RECIP_SH+V_W-1:RECIP_SH] > V_W'(TOP_POINT);
         end
         OP_SEG_SQ: begin
            sq_in  = 36'(s) * 36'(s);
            d9_in  = 10'(d) * 10'(SEG_GAIN);
            hit_in = in_seg;
         end
         OP_SEG_ACC: begin
            num_in   = num_ff + NUM_W'(46'(sq_ff) * 46'(d9_ff));
            below_in = !hit_ff;
         end
         OP_PMUL: begin
            sat_in   = e_gt_cap;
            prod2_in = (CAP_W+14)'(diff) * (CAP_W+14)'(PCT_FULL);
         end
         OP_OUT: begin
            valid_in  = 1'b1;
            pct_in    = above_ff ? PCT_W'(PCT_FULL) : div_q[PCT_W-1:0];
            oabove_in = above_ff;
            obelow_in = below_ff;
            osat_in   = sat_ff;
         end
         default: valid_in = rsp_ready ? 1'b0 : valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      p1_ff     <= p1_in;
      y_ff      <= y_in;
      r100_ff   <= r100_in;
      cap_ff    <= cap_in;
      v_ff      <= v_in;
      above_ff  <= above_in;
      sq_ff     <= sq_in;
      d9_ff     <= d9_in;
      hit_ff    <= hit_in;
      num_ff    <= num_in;
      below_ff  <= below_in;
      sat_ff    <= sat_in;
      prod2_ff  <= prod2_in;
      pct_ff    <= pct_in;
      oabove_ff <= oabove_in;
      obelow_ff <= obelow_in;
      osat_ff   <= osat_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign status.div_done = div_done;
   assign status.above    = above_ff;
   assign status.hit      = hit_ff;
   assign status.out_free = !valid_ff || rsp_ready;

   assign rsp_valid     = valid_ff;
   assign percent_centi = pct_ff;
   assign above_table   = oabove_ff;
   assign below_table   = obelow_ff;
   assign saturated     = osat_ff;

endmodule

// ----- design/battery_energy_gauge_core.sv -----
// Battery charge gauge: each item carries one 12-bit ADC sample and yields one
// result with remaining charge in 0.01 % units plus above/below/saturated flags.
// The sample is scaled to battery voltage with three multiplies (the divide by
// 1100 is a reciprocal multiply), then the voltage table is walked from its top
// one segment at a time, summing segment energy, which is divided by load*100
// and turned into a percentage of capacity. These two divisions run on one
// shared radix-2 divider. An item above the table skips the walk and both
// divisions; otherwise at most TABLE_POINTS-1 segments are walked. A finished
// result sits in an output register, so the next item is taken while it waits.
// Registers at byte addresses 0x00 reference mV, 0x08 load milliohms, 0x10
// capacity mJ.
module battery_energy_gauge_core import bgauge_pkg::*; #(
   parameter int TABLE_POINTS = 20
) (
   input  logic              clock,
   input  logic              reset,
   bgauge_req_if.sink        req_bus,
   bgauge_rsp_if.source      rsp_bus,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [REF_W-1:0]  ref_ff, ref_in;
   logic [LOAD_W-1:0] load_ff, load_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   csr_idx_type       csr_idx;
   logic              csr_wr;
   dp_cmd_type        cmd;
   dp_status_type     status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_idx_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      ref_in  = ref_ff;
      load_in = load_ff;
      cap_in  = cap_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_REF:  ref_in  = csr_pwdata[REF_W-1:0];
            CSR_LOAD: load_in = csr_pwdata[LOAD_W-1:0];
            CSR_CAP:  cap_in  = csr_pwdata[CAP_W-1:0];
            default:  ref_in  = ref_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_REF:  csr_prdata = CSR_DW'(ref_ff);
         CSR_LOAD: csr_prdata = CSR_DW'(load_ff);
         CSR_CAP:  csr_prdata = CSR_DW'(cap_ff);
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff  <= REF_RESET;
         load_ff <= LOAD_RESET;
         cap_ff  <= CAP_RESET;
      end else begin
         ref_ff  <= ref_in;
         load_ff <= load_in;
         cap_ff  <= cap_in;
      end
   end

   bgauge_ctrl #(.TABLE_POINTS(TABLE_POINTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bgauge_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .adc_sample    (req_bus.adc_sample),
      .ref_mv        (ref_ff),
      .load_mohm     (load_ff),
      .cap_mj        (cap_ff),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .percent_centi (rsp_bus.percent_centi),
      .above_table   (rsp_bus.above_table),
      .below_table   (rsp_bus.below_table),
      .saturated     (rsp_bus.saturated)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("gauge took a second item while busy");

   a_above_full: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.above_table |->
         rsp_bus.percent_centi == PCT_W'(PCT_FULL) && !rsp_bus.below_table
         && !rsp_bus.saturated)
      else $error("above-table result not forced to full");

   a_sat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |-> rsp_bus.percent_centi == '0)
      else $error("saturated result not zero");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.percent_centi <= PCT_W'(PCT_FULL))
      else $error("percent out of range");

endmodule
